// ===== rtl/aph_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aph_pkg
// Shared types and constants of the archive path hash block.
// ----------------------------------------------------------------------------
package aph_pkg;

    localparam int DEFAULT_MAX_PATH_BYTES = 256;
    localparam int QUEUE_DEPTH            = 4;

    localparam logic [31:0] TAIL_WORD_0 = 32'h9BE7_4448;
    localparam logic [31:0] TAIL_WORD_1 = 32'h66F4_2C48;
    localparam logic [31:0] KEY_INIT    = 32'hF4FA_8928;
    localparam logic [31:0] LANE_B_INIT = 32'h7758_B42B;
    localparam logic [31:0] LANE_A_INIT = 32'h37A8_470E;
    localparam logic [31:0] KEY_SALT    = 32'h267B_0B11;
    localparam logic [31:0] MUL_A_SET   = 32'h0204_0801;
    localparam logic [31:0] MUL_A_KEEP  = 32'hBFEF_7FDF;
    localparam logic [31:0] MUL_B_SET   = 32'h0080_4021;
    localparam logic [31:0] MUL_B_KEEP  = 32'h7DFE_FBFF;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    // One queued request from the front to the back
    typedef struct packed {
        logic        term;     // path ended: mix tail words and emit
        logic        partial;  // term only: word holds a partial word to mix first
        logic [31:0] word;
    } t_qent;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_FOLD,
        ST_EMIT
    } t_back_state;

    typedef enum logic [1:0] {
        TAIL_PART,
        TAIL_WORD0,
        TAIL_WORD1
    } t_tail;

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = c + CASE_OFFSET;
        end else if (c == CHAR_SLASH) begin
            r = CHAR_BSLASH;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/archive_path_hash.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// archive_path_hash
// Streaming file-path hash: one byte in per cycle while the queue has
// room, one 32-bit hash out per path.
// ----------------------------------------------------------------------------
// Path bytes enter on the slave stream, one per cycle, and a zero byte ends
// the path; its hash then leaves on the master stream. Bytes are lowercased,
// '/' becomes '\', and bytes past MAX_PATH_BYTES are dropped until the zero.
// The front packs bytes into words and passes them through a four-entry
// queue to the mixer, which takes each word through queue pop, operand
// prep, 32x32 multiplies and fold. At the zero the mixer pops the end
// request, runs two tail rounds (three when a partial word is left to mix
// first) and then emits the hash. Input is taken at one byte per cycle
// while the queue has room, so long paths stream at full rate and a new
// path can enter while the previous hash is still being mixed or waits to
// be taken. Short paths sent back to back fill the queue, and the input
// then stalls until the mixer catches up; a hash that is not taken holds
// the mixer in its emit state.
// ----------------------------------------------------------------------------
module archive_path_hash #(
    parameter int MAX_PATH_BYTES = aph_pkg::DEFAULT_MAX_PATH_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] path_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [31:0] hash_value
);
    import aph_pkg::*;

    logic  q_push, q_pop, q_full, q_empty;
    t_qent q_in, q_out;

    aph_front #(
        .MAX_PATH_BYTES(MAX_PATH_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_byte   (s_axis_tdata),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_entry  (q_in)
    );

    aph_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_entry (q_out)
    );

    aph_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_entry   (q_out),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_hash    (m_axis_tdata)
    );

endmodule
`default_nettype wire

// ===== rtl/aph_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aph_front
// Accepts path bytes, folds case and separators, packs words and queues
// word and end-of-path requests for the mixing back end.
// ----------------------------------------------------------------------------
module aph_front #(
    parameter int MAX_PATH_BYTES = aph_pkg::DEFAULT_MAX_PATH_BYTES
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [7:0]   i_byte,
    input  wire logic         i_q_full,
    output logic              o_push,
    output aph_pkg::t_qent    o_entry
);
    import aph_pkg::*;

    localparam int CW = $clog2(MAX_PATH_BYTES + 1);

    logic [31:0]   r_word, n_word;
    logic [1:0]    r_slot, n_slot;
    logic [CW-1:0] r_count, n_count;

    logic          accept;
    logic [7:0]    c_fold;
    logic [31:0]   packed_word;

    assign o_ready     = !i_q_full;
    assign accept      = i_valid && o_ready;
    assign c_fold      = fold_char(i_byte);
    assign packed_word = r_word | ({24'd0, c_fold} << {r_slot, 3'b000});

    always_comb begin
        n_word  = r_word;
        n_slot  = r_slot;
        n_count = r_count;
        o_push  = 1'b0;
        o_entry = '{term: 1'b0, partial: 1'b0, word: packed_word};
        if (accept) begin
            priority if (i_byte == CHAR_NUL) begin
                o_push  = 1'b1;
                o_entry = '{term: 1'b1, partial: (r_slot != 2'd0), word: r_word};
                n_word  = '0;
                n_slot  = '0;
                n_count = '0;
            end else if (r_count >= CW'(MAX_PATH_BYTES)) begin
                // drop bytes past the length limit
            end else begin
                n_count = CW'(r_count + 1'b1);
                n_slot  = r_slot + 2'd1;
                n_word  = packed_word;
                if (r_slot == 2'd3) begin
                    o_push = 1'b1;
                    n_word = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word  <= '0;
            r_slot  <= '0;
            r_count <= '0;
        end else begin
            r_word  <= n_word;
            r_slot  <= n_slot;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/aph_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aph_queue
// Short FIFO of mixing requests between the front and the back end.
// ----------------------------------------------------------------------------
module aph_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  aph_pkg::t_qent    i_entry,
    input  wire logic         i_pop,
    output logic              o_full,
    output logic              o_empty,
    output aph_pkg::t_qent    o_entry
);
    import aph_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_qent         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [NW-1:0] r_used;

    logic do_push, do_pop;

    assign o_full  = (r_used == NW'(QUEUE_DEPTH));
    assign o_empty = (r_used == '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_used   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(r_wr_ptr + 1'b1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(r_rd_ptr + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_used <= NW'(r_used + 1'b1);
            end else if (do_pop && !do_push) begin
                r_used <= NW'(r_used - 1'b1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/aph_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aph_back
// Mixing sequencer: word rounds (operand prep, multiply, end-around
// fold), tail rounds on end of path, and the result register.
// ----------------------------------------------------------------------------
module aph_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_q_empty,
    input  aph_pkg::t_qent    i_entry,
    output logic              o_pop,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [31:0]       o_hash
);
    import aph_pkg::*;

    t_back_state r_state, n_state;
    t_tail       r_tail, n_tail;
    logic        r_term, n_term;
    logic [31:0] r_word, n_word;
    logic [31:0] r_key, n_key;
    logic [31:0] r_lane_a, n_lane_a;
    logic [31:0] r_lane_b, n_lane_b;
    logic [31:0] r_fa, n_fa;
    logic [31:0] r_a_old, n_a_old;
    logic [31:0] r_fb, n_fb;
    logic [31:0] r_b_in, n_b_in;
    logic [63:0] r_prod_a, n_prod_a;
    logic [63:0] r_prod_b, n_prod_b;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_hash, n_hash;

    // round operands
    logic [31:0] key_rot, key_mix, a_x, b_x;
    // lane A fold
    logic [31:0] a_lo, a_hi, a_lo1, fold_a;
    logic [32:0] a_sum;
    // lane B fold
    logic [31:0] b_lo, b_hi, b_lo1, b_dbl, fold_b;
    logic [32:0] b_sum;

    assign o_valid = r_out_valid;
    assign o_hash  = r_hash;

    always_comb begin
        key_rot = {r_key[30:0], r_key[31]};
        key_mix = KEY_SALT ^ key_rot;
        a_x     = r_lane_a ^ r_word;
        b_x     = r_lane_b ^ r_word;

        a_lo   = r_prod_a[31:0];
        a_hi   = r_prod_a[63:32];
        a_lo1  = a_lo + {31'd0, (a_hi != 32'd0)};
        a_sum  = {1'b0, a_lo1} + {1'b0, a_hi};
        fold_a = a_sum[31:0] + {31'd0, a_sum[32]};

        b_lo   = r_prod_b[31:0];
        b_hi   = r_prod_b[63:32];
        b_dbl  = {b_hi[30:0], 1'b0};
        b_lo1  = b_lo + {31'd0, b_hi[31]};
        b_sum  = {1'b0, b_lo1} + {1'b0, b_dbl};
        fold_b = b_sum[31:0] + {30'd0, b_sum[32], 1'b0};
    end

    always_comb begin
        n_state     = r_state;
        n_tail      = r_tail;
        n_term      = r_term;
        n_word      = r_word;
        n_key       = r_key;
        n_lane_a    = r_lane_a;
        n_lane_b    = r_lane_b;
        n_fa        = r_fa;
        n_a_old     = r_a_old;
        n_fb        = r_fb;
        n_b_in      = r_b_in;
        n_prod_a    = r_prod_a;
        n_prod_b    = r_prod_b;
        n_hash      = r_hash;
        n_out_valid = r_out_valid && !i_ready;
        o_pop       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_term  = i_entry.term;
                    n_state = ST_PREP;
                    if (i_entry.term && !i_entry.partial) begin
                        n_word = TAIL_WORD_0;
                        n_tail = TAIL_WORD0;
                    end else begin
                        n_word = i_entry.word;
                        n_tail = TAIL_PART;
                    end
                end
            end
            ST_PREP: begin
                n_key   = key_rot;
                n_a_old = a_x;
                n_b_in  = b_x;
                n_fa    = ((key_mix + b_x) | MUL_A_SET) & MUL_A_KEEP;
                n_fb    = ((key_mix + a_x) | MUL_B_SET) & MUL_B_KEEP;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_prod_a = {32'd0, r_fa} * {32'd0, r_a_old};
                n_prod_b = {32'd0, r_b_in} * {32'd0, r_fb};
                n_state  = ST_FOLD;
            end
            ST_FOLD: begin
                n_lane_a = fold_a;
                n_lane_b = fold_b;
                if (!r_term) begin
                    n_state = ST_IDLE;
                end else begin
                    unique case (r_tail)
                        TAIL_PART: begin
                            n_word  = TAIL_WORD_0;
                            n_tail  = TAIL_WORD0;
                            n_state = ST_PREP;
                        end
                        TAIL_WORD0: begin
                            n_word  = TAIL_WORD_1;
                            n_tail  = TAIL_WORD1;
                            n_state = ST_PREP;
                        end
                        TAIL_WORD1: begin
                            n_state = ST_EMIT;
                        end
                        default: begin
                            n_state = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_hash      = r_lane_a ^ r_lane_b;
                    n_key       = KEY_INIT;
                    n_lane_a    = LANE_A_INIT;
                    n_lane_b    = LANE_B_INIT;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tail      <= TAIL_PART;
            r_term      <= 1'b0;
            r_key       <= KEY_INIT;
            r_lane_a    <= LANE_A_INIT;
            r_lane_b    <= LANE_B_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tail      <= n_tail;
            r_term      <= n_term;
            r_key       <= n_key;
            r_lane_a    <= n_lane_a;
            r_lane_b    <= n_lane_b;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_fa     <= n_fa;
        r_a_old  <= n_a_old;
        r_fb     <= n_fb;
        r_b_in   <= n_b_in;
        r_prod_a <= n_prod_a;
        r_prod_b <= n_prod_b;
        r_hash   <= n_hash;
    end

endmodule
`default_nettype wire

// ===== tb/sv/archive_path_hash_check.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// archive_path_hash_check
// Watches both streams of the path hash block, predicts and compares.
// ----------------------------------------------------------------------------
// Every accepted path byte is run through a local copy of the hash state;
// a zero byte finishes the path and queues its expected hash. Each hash
// taken from the master stream is compared with the oldest queued one.
// Unexpected hashes and wrong values count as failures; the number of
// hashes still owed is handed back so the top can judge leftovers.
// ----------------------------------------------------------------------------
module archive_path_hash_check #(
    parameter int MAX_PATH_BYTES = aph_pkg::DEFAULT_MAX_PATH_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        i_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] path_byte
    input  wire logic        i_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [31:0] i_m_axis_tdata,   // [31:0] hash_value
    output int               o_fail_count,
    output int               o_pending,
    output int               o_hash_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import aph_pkg::*;

    localparam int SHOW_LIMIT = 10;

    logic [31:0] word_buf;
    logic [1:0]  slot;
    int unsigned path_len;
    logic [31:0] rot_key;
    logic [31:0] lane_a;
    logic [31:0] lane_b;

    logic [31:0] hash_q[$];
    int          fails  = 0;
    int          shown  = 0;
    int          hashes = 0;

    function automatic void clear_path();
        word_buf = '0;
        slot     = '0;
        path_len = 0;
        rot_key  = KEY_INIT;
        lane_a   = LANE_A_INIT;
        lane_b   = LANE_B_INIT;
    endfunction

    // One word round: rotate the key, then two multiplies with end-around folding
    function automatic void mix_round(input logic [31:0] w);
        logic [31:0] k, fa, fb, lo, hi, t, a_old, dbl;
        logic [63:0] prod, sum;
        rot_key = {rot_key[30:0], rot_key[31]};
        k       = KEY_SALT ^ rot_key;
        lane_a  = lane_a ^ w;
        lane_b  = lane_b ^ w;
        a_old   = lane_a;

        fa   = ((k + lane_b) | MUL_A_SET) & MUL_A_KEEP;
        prod = 64'(fa) * 64'(a_old);
        lo   = prod[31:0];
        hi   = prod[63:32];
        if (hi != '0) lo = lo + 32'd1;
        sum = 64'(lo) + 64'(hi);
        t   = sum[31:0];
        if (sum[63:32] != '0) t = t + 32'd1;
        lane_a = t;

        fb   = ((k + a_old) | MUL_B_SET) & MUL_B_KEEP;
        prod = 64'(lane_b) * 64'(fb);
        lo   = prod[31:0];
        hi   = prod[63:32];
        sum  = 64'(hi) + 64'(hi);
        dbl  = sum[31:0];
        if (sum[63:32] != '0) lo = lo + 32'd1;
        sum = 64'(lo) + 64'(dbl);
        t   = sum[31:0];
        if (sum[63:32] != '0) t = t + 32'd2;
        lane_b = t;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        logic [7:0] c;
        if (b == CHAR_NUL) begin
            if (slot != '0) mix_round(word_buf);
            mix_round(TAIL_WORD_0);
            mix_round(TAIL_WORD_1);
            hash_q.push_back(lane_a ^ lane_b);
            clear_path();
        end else if (path_len < MAX_PATH_BYTES) begin
            c = b;
            if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
                c = b + CASE_OFFSET;
            end else if (b == CHAR_SLASH) begin
                c = CHAR_BSLASH;
            end
            word_buf = word_buf | (32'(c) << {slot, 3'b000});
            path_len = path_len + 1;
            slot     = slot + 2'd1;
            if (slot == '0) begin
                mix_round(word_buf);
                word_buf = '0;
            end
        end
        // drop bytes past the length cap until the zero arrives
    endfunction

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            clear_path();
            hash_q.delete();
        end else begin
            // take the result side first: a byte of this edge cannot produce it
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                hashes++;
                if (hash_q.size() == 0) begin
                    fails++;
                    if (shown < SHOW_LIMIT) begin
                        shown++;
                        $display("[%0t] unexpected hash %08h, none pending",
                                 $realtime, i_m_axis_tdata);
                    end
                end else begin
                    want = hash_q.pop_front();
                    if (i_m_axis_tdata !== want) begin
                        fails++;
                        if (shown < SHOW_LIMIT) begin
                            shown++;
                            $display("[%0t] hash mismatch: expected %08h, actual %08h",
                                     $realtime, want, i_m_axis_tdata);
                        end
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) absorb_byte(i_s_axis_tdata);
        end
        o_fail_count <= fails;
        o_pending    <= hash_q.size();
        o_hash_count <= hashes;
    end

endmodule
`default_nettype wire

// ===== tb/sv/archive_path_hash_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// archive_path_hash_test
// Stimulus and verdict for the archive path hash block.
// ----------------------------------------------------------------------------
// Sends a handful of hand-picked paths (empty path, case and slash folding
// edges, word-aligned length, high bytes), then random paths of mixed
// length including some past the length cap, with random gaps on the
// input and random stalls on the output. The checker beside the block
// predicts every hash and reports failures back here.
// ----------------------------------------------------------------------------
module archive_path_hash_test;
    timeunit 1ns;
    timeprecision 1ps;

    import aph_pkg::*;

    localparam int MAX_BYTES    = DEFAULT_MAX_PATH_BYTES;
    localparam int ITEM_BUDGET  = 1450;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_TICKS = 40;

    typedef logic [7:0] path_t[$];

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    int fail_count;
    int pending;
    int hash_count;

    bit calm       = 1'b1;
    int stall_left = 0;
    int cycles     = 0;
    int items_sent = 0;
    int bytes_sent = 0;
    int long_paths = 0;

    archive_path_hash #(
        .MAX_PATH_BYTES (MAX_BYTES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    archive_path_hash_check #(
        .MAX_PATH_BYTES (MAX_BYTES)
    ) u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_hash_count    (hash_count)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d hashes outstanding", cycles, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly short pauses, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            m_axis_tready <= 1'b0;
            stall_left    <= gap_len() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int g;
        g = (!calm && $urandom_range(0, 99) < 30) ? gap_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Send the path bytes, then the zero that closes it
    task automatic send_path(input path_t p);
        foreach (p[i]) send_byte(p[i]);
        send_byte(CHAR_NUL);
        items_sent += ((p.size() < MAX_BYTES) ? p.size() : MAX_BYTES) + 1;
        if (p.size() > MAX_BYTES) long_paths++;
    endtask

    task automatic send_packed(input logic [63:0] bytes, input int n);
        path_t p;
        for (int i = 0; i < n; i++) p.push_back(bytes[8*i +: 8]);
        send_path(p);
    endtask

    // Hold the input until every hash owed has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return 8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
        if (r < 40) return CHAR_SLASH;
        if (r < 65) return 8'($urandom_range(8'h61, 8'h7A));
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic int pick_len(input int path_no);
        int r;
        // force the length-cap edges early on
        if (path_no == 3) return MAX_BYTES;
        if (path_no == 9) return MAX_BYTES + 1;
        if (path_no == 20) return MAX_BYTES + $urandom_range(2, 60);
        r = $urandom_range(0, 999);
        if (r < 80) return $urandom_range(0, 4);
        if (r < 750) return $urandom_range(1, 16);
        if (r < 990) return $urandom_range(17, 64);
        return $urandom_range(MAX_BYTES - 8, MAX_BYTES + 24);
    endfunction

    initial begin
        path_t p;
        int    len;
        int    path_no;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        calm = 1'b1;
        send_packed(64'h0, 0);                      // empty path
        send_packed(64'h5B_40_2F_5A_41, 5);         // fold edges: A Z / @ [
        send_packed(64'h5C_61_7A_60, 4);            // word-aligned, no partial word
        send_packed(64'h2E_30_3F_01_7F_FF_80, 7);   // high bytes pass unfolded
        drain();

        path_no = 0;
        while (items_sent < ITEM_BUDGET) begin
            calm = ($urandom_range(0, 99) < 20);
            len  = pick_len(path_no);
            p.delete();
            for (int i = 0; i < len; i++) p.push_back(pick_char());
            send_path(p);
            path_no++;
            if ($urandom_range(0, 99) < 4) drain();
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b1;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);

        $display("Hashed %0d paths from %0d bytes; %0d paths ran past the %0d-byte cap.",
                 hash_count, bytes_sent, long_paths, MAX_BYTES);
        $display("Input gaps and output stalls were mixed with stall-free stretches.");
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d failures, %0d hashes never arrived", fail_count, pending);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/aph_pkg.sv
rtl/aph_front.sv
rtl/aph_queue.sv
rtl/aph_back.sv
rtl/archive_path_hash.sv
tb/sv/archive_path_hash_check.sv
tb/sv/archive_path_hash_test.sv
